// File: design/tdt_pkg.sv
package tdt_pkg;

    localparam int FRAME_W = 20;
    localparam int POS_W   = 32;
    localparam int CFG_W   = 18;
    localparam int SYM_W   = 8;

    localparam logic signed [FRAME_W-1:0] FRAME_MAX = 20'sh7FFFF;
    localparam logic signed [FRAME_W-1:0] FRAME_MIN = 20'sh80000;

    // Command characters
    localparam logic [SYM_W-1:0] SYM_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] SYM_AMP    = 8'h26;
    localparam logic [SYM_W-1:0] SYM_BSLASH = 8'h5C;
    localparam logic [SYM_W-1:0] SYM_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_BAR    = 8'h7C;
    localparam logic [SYM_W-1:0] SYM_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] SYM_RPAREN = 8'h29;

    // Configuration register indexes
    localparam logic CFG_COS = 1'b0;
    localparam logic CFG_SIN = 1'b1;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             draws;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] start_z;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
        logic signed [POS_W-1:0] end_z;
        logic                    stack_overflow;
    } out_item_t;

    typedef logic [2:0][FRAME_W-1:0] vec_t;

    // Position and frame; frame holds heading, left, up at 0..2, 3..5, 6..8
    typedef struct packed {
        logic [2:0][POS_W-1:0]   pos;
        logic [8:0][FRAME_W-1:0] frm;
    } pose_t;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_ROT  = 3'd1,
        OP_FLIP = 3'd2,
        OP_PUSH = 3'd3,
        OP_POP  = 3'd4,
        OP_MOVE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        PAIR_HL = 2'd0,
        PAIR_HU = 2'd1,
        PAIR_LU = 2'd2
    } pair_t;

    typedef struct packed {
        op_t   op;
        pair_t pair;
        logic  neg;
        logic  draws;
        logic  fwd;
    } stage_t;

endpackage

// File: design/turtle_3d_interpreter.sv
// A drawing symbol passes through the decode stage, then the pose update stage loads its
// segment into the output register. Throughput: one symbol per cycle; input stalls
// only while the decode stage holds a drawing symbol and the output register holds a
// segment not yet taken. A pop reads the pose stack memory in the decode cycle.
// Reset: pose at origin with identity frame, stack empty, overflow flag clear,
// cosine 1.0 and sine 0; stack memory contents are not cleared.
module turtle_3d_interpreter #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tdt_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tdt_pkg::out_item_t         out_data,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [tdt_pkg::CFG_W-1:0]  cfg_wdata
);
    import tdt_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
    localparam logic [FRAME_W-1:0] FRAME_ONE =
        (FRAC_BITS >= FRAME_W - 1) ? FRAME_MAX : FRAME_W'(1 << FRAC_BITS);
    localparam logic [8:0][FRAME_W-1:0] FRAME_INIT =
        {FRAME_ONE, {3{FRAME_W'(0)}}, FRAME_ONE, {3{FRAME_W'(0)}}, FRAME_ONE};

    function automatic logic [FRAME_W-1:0] neg_sat(input logic [FRAME_W-1:0] v);
        logic [FRAME_W-1:0] r;
        if (v == FRAME_MIN)
            r = FRAME_MAX;
        else
            r = -v;
        return r;
    endfunction

    function automatic logic [POS_W-1:0] add_sat(input logic [POS_W-1:0] p,
                                                 input logic [FRAME_W-1:0] d);
        logic signed [POS_W:0] s;
        logic [POS_W-1:0]      r;
        s = (POS_W+1)'($signed(p)) + (POS_W+1)'($signed(d));
        if (s[POS_W] != s[POS_W-1])
            r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        else
            r = s[POS_W-1:0];
        return r;
    endfunction

    logic signed [CFG_W-1:0] cos_reg;
    logic signed [CFG_W-1:0] sin_reg;

    pose_t           pose_reg;
    pose_t           pose_next;
    logic [SP_W-1:0] sp_reg;
    logic [SP_W-1:0] sp_next;
    logic [SP_W-1:0] sp_dec;
    logic            ovf_reg;
    logic            ovf_next;

    logic            a_valid_reg;
    logic            a_valid_next;
    stage_t          a_reg;
    stage_t          dec;
    logic [AW-1:0]   a_addr_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    out_item_t       out_reg;

    logic            accept;
    logic            emit;
    logic            b_fire;
    logic            out_load;

    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    pose_t           mem_rdata;

    logic signed [CFG_W:0] s_pos;
    logic signed [CFG_W:0] s_neg;
    logic signed [CFG_W:0] k_p;
    logic signed [CFG_W:0] k_q;
    vec_t            rot_a;
    vec_t            rot_b;
    vec_t            rot_p;
    vec_t            rot_q;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= 18'sd65536;
            sin_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_COS: cos_reg <= cfg_wdata;
                CFG_SIN: sin_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake control
    assign emit     = (a_reg.op == OP_MOVE) && a_reg.draws;
    assign b_fire   = a_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign out_load = b_fire && emit;
    assign in_ready = !a_valid_reg || b_fire;
    assign accept   = in_valid && in_ready;
    assign sp_dec   = sp_reg - 1'b1;

    // Decode symbol, move stack pointer, flag a push on a full stack, issue stack read for a pop
    always_comb
    begin
        dec       = '{op: OP_NOP, pair: PAIR_HL, neg: 1'b0, draws: in_data.draws, fwd: 1'b0};
        sp_next   = sp_reg;
        ovf_next  = ovf_reg;
        mem_re    = 1'b0;
        mem_raddr = sp_dec[AW-1:0];
        case (in_data.symbol)
            SYM_PLUS:
            begin
                dec.op = OP_ROT;
                dec.pair = PAIR_HL;
            end
            SYM_MINUS:
            begin
                dec.op = OP_ROT;
                dec.pair = PAIR_HL;
                dec.neg = 1'b1;
            end
            SYM_CARET:
            begin
                dec.op = OP_ROT;
                dec.pair = PAIR_HU;
            end
            SYM_AMP:
            begin
                dec.op = OP_ROT;
                dec.pair = PAIR_HU;
                dec.neg = 1'b1;
            end
            SYM_BSLASH:
            begin
                dec.op = OP_ROT;
                dec.pair = PAIR_LU;
                dec.neg = 1'b1;
            end
            SYM_SLASH:
            begin
                dec.op = OP_ROT;
                dec.pair = PAIR_LU;
            end
            SYM_BAR:
                dec.op = OP_FLIP;
            SYM_LPAREN:
            begin
                if (sp_reg < SP_FULL)
                begin
                    dec.op  = OP_PUSH;
                    sp_next = sp_reg + 1'b1;
                end
                else
                    ovf_next = 1'b1;
            end
            SYM_RPAREN:
            begin
                if (sp_reg != '0)
                begin
                    dec.op  = OP_POP;
                    // the pose being pushed right now is the one to restore
                    dec.fwd = a_valid_reg && (a_reg.op == OP_PUSH);
                    sp_next = sp_dec;
                    mem_re  = accept;
                end
            end
            default:
                dec.op = OP_MOVE;
        endcase
        if (!accept)
        begin
            sp_next  = sp_reg;
            ovf_next = ovf_reg;
        end
    end

    always_comb
    begin
        if (accept)
            a_valid_next = 1'b1;
        else if (b_fire)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    // Decode stage and stack bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_reg       <= '{op: OP_NOP, pair: PAIR_HL, neg: 1'b0, draws: 1'b0, fwd: 1'b0};
            sp_reg      <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            sp_reg      <= sp_next;
            ovf_reg     <= ovf_next;
            if (accept)
                a_reg <= dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            a_addr_reg <= sp_reg[AW-1:0];
    end

    // Rotation operands
    assign s_pos = (CFG_W+1)'(sin_reg);
    assign s_neg = -s_pos;
    assign k_p   = a_reg.neg ? s_neg : s_pos;
    assign k_q   = a_reg.neg ? s_pos : s_neg;

    always_comb
    begin
        case (a_reg.pair)
            PAIR_HL:
            begin
                rot_a = pose_reg.frm[2:0];
                rot_b = pose_reg.frm[5:3];
            end
            PAIR_HU:
            begin
                rot_a = pose_reg.frm[2:0];
                rot_b = pose_reg.frm[8:6];
            end
            PAIR_LU:
            begin
                rot_a = pose_reg.frm[5:3];
                rot_b = pose_reg.frm[8:6];
            end
            default:
            begin
                rot_a = pose_reg.frm[2:0];
                rot_b = pose_reg.frm[5:3];
            end
        endcase
    end

    // One lane per axis: p' = p*c + q*s, q' = q*c - p*s
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        tdt_mix #(.FRAC_BITS(FRAC_BITS)) u_mix_p (
            .x   (rot_a[i]),
            .y   (rot_b[i]),
            .c   (cos_reg),
            .k   (k_p),
            .res (rot_p[i])
        );
        tdt_mix #(.FRAC_BITS(FRAC_BITS)) u_mix_q (
            .x   (rot_b[i]),
            .y   (rot_a[i]),
            .c   (cos_reg),
            .k   (k_q),
            .res (rot_q[i])
        );
    end

    // Apply the decoded operation to the pose
    always_comb
    begin
        pose_next = pose_reg;
        case (a_reg.op)
            OP_ROT:
            begin
                case (a_reg.pair)
                    PAIR_HL:
                    begin
                        pose_next.frm[2:0] = rot_p;
                        pose_next.frm[5:3] = rot_q;
                    end
                    PAIR_HU:
                    begin
                        pose_next.frm[2:0] = rot_p;
                        pose_next.frm[8:6] = rot_q;
                    end
                    PAIR_LU:
                    begin
                        pose_next.frm[5:3] = rot_p;
                        pose_next.frm[8:6] = rot_q;
                    end
                    default: ;
                endcase
            end
            OP_FLIP:
            begin
                for (int j = 0; j < 6; j++)
                    pose_next.frm[j] = neg_sat(pose_reg.frm[j]);
            end
            OP_POP:
            begin
                if (!a_reg.fwd)
                    pose_next = mem_rdata;
            end
            OP_MOVE:
            begin
                for (int j = 0; j < 3; j++)
                    pose_next.pos[j] = add_sat(pose_reg.pos[j], pose_reg.frm[j]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pose_reg <= '{pos: '0, frm: FRAME_INIT};
        else if (b_fire)
            pose_reg <= pose_next;
    end

    // Pose stack
    assign mem_we = b_fire && (a_reg.op == OP_PUSH);

    tdt_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (a_addr_reg),
        .wr_data (pose_reg),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Output register
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= '{start_x:        pose_reg.pos[0],
                         start_y:        pose_reg.pos[1],
                         start_z:        pose_reg.pos[2],
                         end_x:          pose_next.pos[0],
                         end_y:          pose_next.pos[1],
                         end_z:          pose_next.pos[2],
                         stack_overflow: ovf_reg};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond stack depth");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_raddr == a_addr_reg) && dec.fwd)
        else $error("stack read and write collide without forwarding");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("segment overwrites a pending transaction");

endmodule

// File: design/tdt_mix.sv
module tdt_mix #(
    parameter int FRAC_BITS = 16
) (
    input  logic signed [tdt_pkg::FRAME_W-1:0] x,
    input  logic signed [tdt_pkg::FRAME_W-1:0] y,
    input  logic signed [tdt_pkg::CFG_W-1:0]   c,
    input  logic signed [tdt_pkg::CFG_W:0]     k,
    output logic signed [tdt_pkg::FRAME_W-1:0] res
);
    import tdt_pkg::*;

    localparam int SUM_W = FRAME_W + CFG_W + 3;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    logic signed [FRAME_W+CFG_W-1:0] prod_c;
    logic signed [FRAME_W+CFG_W:0]   prod_k;
    logic signed [SUM_W-1:0]         sum;
    logic signed [SUM_W-1:0]         scaled;

    // x*c + y*k, round half up, drop fraction bits, clamp to frame range
    always_comb
    begin
        prod_c = x * c;
        prod_k = y * k;
        sum    = SUM_W'(prod_c) + SUM_W'(prod_k) + HALF;
        scaled = sum >>> FRAC_BITS;
        if (scaled > SUM_W'(FRAME_MAX))
            res = FRAME_MAX;
        else if (scaled < SUM_W'(FRAME_MIN))
            res = FRAME_MIN;
        else
            res = scaled[FRAME_W-1:0];
    end

endmodule

// File: design/tdt_stack_mem.sv
module tdt_stack_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  tdt_pkg::pose_t    wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output tdt_pkg::pose_t    rd_data
);
    import tdt_pkg::*;

    pose_t mem [DEPTH];

    // Write saved pose
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read of the entry to restore
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// File: tb/sv/turtle_path_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own turtle state,
// and compares every segment that leaves the block with the predicted one.
module turtle_path_checker #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  tdt_pkg::in_item_t          in_data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  tdt_pkg::out_item_t         out_data,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [tdt_pkg::CFG_W-1:0]  cfg_wdata,
    output int                         errors,
    output int                         pending,
    output int                         seg_count
);
    import tdt_pkg::*;

    // Turtle state: pose, angle, saved poses, overflow flag
    pose_t     pose;
    pose_t     pose_stack [STACK_DEPTH];
    int        depth;
    logic      overflow_flag;
    longint    cos_q;
    longint    sin_q;
    out_item_t segments_due [$];
    out_item_t want;

    function automatic logic [FRAME_W-1:0] clamp_frame(longint v);
        if (v > longint'(FRAME_MAX))
            return FRAME_MAX;
        if (v < longint'(FRAME_MIN))
            return FRAME_MIN;
        return v[FRAME_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[POS_W-1:0];
    endfunction

    // a*c + b*s scaled down, rounded half up (floor after adding half)
    function automatic logic [FRAME_W-1:0] mix(logic [FRAME_W-1:0] a, logic [FRAME_W-1:0] b,
                                              longint c, longint s);
        longint acc;
        acc = longint'($signed(a)) * c + longint'($signed(b)) * s
            + (longint'(1) <<< (FRAC_BITS - 1));
        return clamp_frame(acc >>> FRAC_BITS);
    endfunction

    // Rotate frame vectors p and q: p' = p*c + q*s, q' = q*c - p*s
    function automatic void turn(int p, int q, longint c, longint s);
        logic [FRAME_W-1:0] a;
        logic [FRAME_W-1:0] b;
        for (int i = 0; i < 3; i++)
        begin
            a = pose.frm[p + i];
            b = pose.frm[q + i];
            pose.frm[p + i] = mix(a, b, c, s);
            pose.frm[q + i] = mix(b, a, c, -s);
        end
    endfunction

    // Apply one symbol to the turtle and queue the segment it draws, if any
    function automatic void interpret_symbol(in_item_t it);
        out_item_t seg;
        case (it.symbol)
            SYM_PLUS:   turn(0, 3, cos_q, sin_q);
            SYM_MINUS:  turn(0, 3, cos_q, -sin_q);
            SYM_CARET:  turn(0, 6, cos_q, sin_q);
            SYM_AMP:    turn(0, 6, cos_q, -sin_q);
            SYM_BSLASH: turn(3, 6, cos_q, -sin_q);
            SYM_SLASH:  turn(3, 6, cos_q, sin_q);
            SYM_BAR:
            begin
                for (int i = 0; i < 6; i++)
                    pose.frm[i] = clamp_frame(-longint'($signed(pose.frm[i])));
            end
            SYM_LPAREN:
            begin
                if (depth < STACK_DEPTH)
                begin
                    pose_stack[depth] = pose;
                    depth++;
                end
                else
                    overflow_flag = 1'b1;
            end
            SYM_RPAREN:
            begin
                // a pop on an empty stack does nothing
                if (depth > 0)
                begin
                    depth--;
                    pose = pose_stack[depth];
                end
            end
            default:
            begin
                seg.start_x = pose.pos[0];
                seg.start_y = pose.pos[1];
                seg.start_z = pose.pos[2];
                for (int i = 0; i < 3; i++)
                    pose.pos[i] = clamp_pos(longint'($signed(pose.pos[i]))
                                            + longint'($signed(pose.frm[i])));
                seg.end_x = pose.pos[0];
                seg.end_y = pose.pos[1];
                seg.end_z = pose.pos[2];
                seg.stack_overflow = overflow_flag;
                if (it.draws)
                    segments_due = {segments_due, seg};
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [POS_W-1:0] exp_v,
                                 input logic [POS_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose.pos      = '0;
            pose.frm      = '0;
            pose.frm[0]   = clamp_frame(longint'(1) <<< FRAC_BITS);
            pose.frm[4]   = clamp_frame(longint'(1) <<< FRAC_BITS);
            pose.frm[8]   = clamp_frame(longint'(1) <<< FRAC_BITS);
            depth         = 0;
            overflow_flag = 1'b0;
            cos_q         = 65536;
            sin_q         = 0;
            errors        = 0;
            seg_count     = 0;
            segments_due.delete();
        end
        else
        begin
            // track register writes
            if (cfg_wr_en)
            begin
                if (cfg_addr == CFG_COS)
                    cos_q = longint'($signed(cfg_wdata));
                else
                    sin_q = longint'($signed(cfg_wdata));
            end

            // check an outgoing segment against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (segments_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected segment, expected none, actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = segments_due.pop_front();
                    compare_field("start_x", want.start_x, out_data.start_x);
                    compare_field("start_y", want.start_y, out_data.start_y);
                    compare_field("start_z", want.start_z, out_data.start_z);
                    compare_field("end_x", want.end_x, out_data.end_x);
                    compare_field("end_y", want.end_y, out_data.end_y);
                    compare_field("end_z", want.end_z, out_data.end_z);
                    compare_field("stack_overflow", POS_W'(want.stack_overflow),
                                  POS_W'(out_data.stack_overflow));
                    seg_count++;
                end
            end

            // advance the turtle for an accepted symbol
            if (in_valid && in_ready)
                interpret_symbol(in_data);
        end
        pending = segments_due.size();
    end

endmodule

// File: tb/sv/tb_turtle_3d_interpreter.sv
`timescale 1ns / 100ps

module tb_turtle_3d_interpreter;
    import tdt_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int LONG_HOLD   = 400;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_addr  = CFG_COS;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    int   errors;
    int   pending;
    int   seg_count;
    int   cycles     = 0;
    int   sent       = 0;
    int   hold_asks  = 0;
    int   hold_given = 0;
    int   out_stall  = 0;
    logic calm_tx    = 1'b0;
    logic calm_rx    = 1'b0;

    turtle_3d_interpreter #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    turtle_path_checker #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending),
        .seg_count (seg_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic is_command(logic [SYM_W-1:0] s);
        case (s)
            SYM_PLUS, SYM_MINUS, SYM_CARET, SYM_AMP, SYM_BSLASH, SYM_SLASH,
            SYM_BAR, SYM_LPAREN, SYM_RPAREN: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] plain_symbol();
        logic [SYM_W-1:0] s;
        do
            s = SYM_W'($urandom_range(0, 255));
        while (is_command(s));
        return s;
    endfunction

    function automatic logic [SYM_W-1:0] turn_symbol();
        case ($urandom_range(0, 5))
            0: return SYM_PLUS;
            1: return SYM_MINUS;
            2: return SYM_CARET;
            3: return SYM_AMP;
            4: return SYM_BSLASH;
            default: return SYM_SLASH;
        endcase
    endfunction

    // Timeout and cycle count
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d segments still due", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off on request
    always @(posedge clk)
    begin
        if (cycles % 300 == 0)
            calm_rx <= ($urandom_range(0, 3) == 0);
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_given != hold_asks)
        begin
            hold_given <= hold_asks;
            out_stall  <= LONG_HOLD;
            out_ready  <= 1'b0;
        end
        else if (out_stall != 0)
        begin
            out_stall <= out_stall - 1;
            out_ready <= (out_stall == 1);
        end
        else if (!calm_rx && $urandom_range(0, 3) == 0)
        begin
            out_stall <= gap_len();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one symbol, idling first at random; return at the accepting edge
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic drw);
        if (!calm_tx && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{symbol: sym, draws: drw};
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        if (sent % 150 == 0)
            calm_tx = ($urandom_range(0, 3) == 0);
    endtask

    // Stop offering, wait for every due segment, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_angle(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] s);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_COS;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_addr  <= CFG_SIN;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Branching L-system strings with random content plus some noise
    task automatic random_phase(input int count);
        int nest;
        int pick;
        nest = 0;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_symbol(plain_symbol(), $urandom_range(0, 9) < 7);
            else if (pick < 65)
                send_symbol(turn_symbol(), 1'($urandom_range(0, 1)));
            else if (pick < 77 && nest < 12)
            begin
                send_symbol(SYM_LPAREN, 1'($urandom_range(0, 1)));
                nest++;
            end
            else if (pick < 89 && nest > 0)
            begin
                send_symbol(SYM_RPAREN, 1'($urandom_range(0, 1)));
                nest--;
            end
            else if (pick < 89)
                send_symbol($urandom_range(0, 4) == 0 ? SYM_RPAREN : plain_symbol(), 1'b1);
            else if (pick < 93)
                send_symbol(SYM_BAR, 1'($urandom_range(0, 1)));
            else
                send_symbol(SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        // close open branches
        while (nest > 0)
        begin
            send_symbol(SYM_RPAREN, 1'($urandom_range(0, 1)));
            nest--;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command, field extremes, push/pop, empty pop
        set_angle(18'sd56756, 18'sd32768);
        send_symbol(SYM_LPAREN, 1'b1);
        send_symbol(8'h46, 1'b1);
        send_symbol(SYM_PLUS, 1'b0);
        send_symbol(SYM_MINUS, 1'b1);
        send_symbol(SYM_CARET, 1'b0);
        send_symbol(SYM_AMP, 1'b1);
        send_symbol(SYM_BSLASH, 1'b0);
        send_symbol(SYM_SLASH, 1'b1);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b1);
        send_symbol(SYM_BAR, 1'b1);
        send_symbol(8'h41, 1'b0);
        send_symbol(8'h7F, 1'b1);
        send_symbol(SYM_LPAREN, 1'b0);
        send_symbol(SYM_PLUS, 1'b1);
        send_symbol(8'h46, 1'b1);
        send_symbol(SYM_RPAREN, 1'b0);
        send_symbol(8'h46, 1'b1);
        send_symbol(SYM_RPAREN, 1'b1);
        send_symbol(SYM_RPAREN, 1'b1);
        send_symbol(8'h47, 1'b1);

        // Saturation run: grow heading to full scale, take full-scale steps,
        // negate the most negative heading value, then restore the saved pose
        settle();
        set_angle(18'sd65536, 18'sd65536);
        send_symbol(SYM_LPAREN, 1'b0);
        repeat (7) send_symbol(SYM_PLUS, 1'b0);
        for (int i = 0; i < 40; i++)
            send_symbol(plain_symbol(), (i % 4 == 0));
        send_symbol(SYM_BAR, 1'b0);
        repeat (3) send_symbol(plain_symbol(), 1'b1);
        send_symbol(SYM_RPAREN, 1'b0);

        // Random phases over several angle settings
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0: set_angle(18'sd46341, -18'sd46341);
                1: set_angle(18'sd0, 18'sd65536);
                2: set_angle(-18'sd65536, 18'sd0);
                3: set_angle(18'sd131071, CFG_W'(-131072));
                4: set_angle(CFG_W'($urandom_range(0, 262143)),
                             CFG_W'($urandom_range(0, 262143)));
                default: set_angle(18'sd56756, 18'sd32768);
            endcase
            // long receiver hold-off while symbols keep coming
            if (ph == 1)
                hold_asks++;
            random_phase(170);
            // overfill the stack, draw with the sticky flag set, then unwind
            if (ph == 3)
            begin
                repeat (STACK_DEPTH + 6) send_symbol(SYM_LPAREN, 1'($urandom_range(0, 1)));
                repeat (6) send_symbol(plain_symbol(), 1'b1);
                repeat (STACK_DEPTH + 6) send_symbol(SYM_RPAREN, 1'($urandom_range(0, 1)));
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Sent %0d symbols: commands, frame saturation, stack overflow, 7 angles",
                 sent);
        $display("Compared %0d drawn segments field by field", seg_count);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
